// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/dsas_pkg.sv =====
// Shared types and constants of the DHCPv4 server address select unit.
package dsas_pkg;

   typedef logic [1:0] status_type;

   localparam status_type ST_NEXT_SERVER = 2'd0;
   localparam status_type ST_SERVER_ID   = 2'd1;
   localparam status_type ST_NOT_FOUND   = 2'd2;

   localparam logic [7:0] CODE_PAD       = 8'd0;
   localparam logic [7:0] CODE_SERVER_ID = 8'd54;
   localparam logic [7:0] CODE_END       = 8'd255;
   localparam logic [7:0] SID_LEN        = 8'd4;

   typedef struct packed {
      logic [7:0]  option_byte;
      logic        first_byte;
      logic [31:0] next_server;
      logic        last_byte;
   } item_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [31:0] server_addr;
   } result_type;

endpackage

// ===== hw/rtl/dsas_scan.sv =====
// Option walk state machine: updates the scan state for one byte and forms the result.
module dsas_scan
   import dsas_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output result_type result
);

   typedef enum logic [4:0] {
      PH_DONE      = 5'b00001,
      PH_CODE      = 5'b00010,
      PH_LEN_OTHER = 5'b00100,
      PH_LEN_SID   = 5'b01000,
      PH_VALUE     = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in, cur;
   logic [7:0]  left_ff, left_in, left_dec;
   logic        capt_ff, capt_in;
   logic [31:0] addr_ff, addr_in, addr_shift;
   logic        emit;
   status_type  emit_status;
   logic [31:0] emit_addr;

   always_comb begin
      cur         = phase_ff;
      left_in     = left_ff;
      capt_in     = capt_ff;
      addr_in     = addr_ff;
      emit        = 1'b0;
      emit_status = ST_NOT_FOUND;
      emit_addr   = '0;
      left_dec    = left_ff - 8'd1;
      addr_shift  = {addr_ff[23:0], item.option_byte};

      // A first byte abandons any walk in progress and starts over.
      if (item.first_byte) begin
         cur     = PH_CODE;
         left_in = '0;
         capt_in = 1'b0;
         addr_in = '0;
      end
      phase_in = cur;

      if (item.first_byte && (item.next_server != 32'd0)) begin
         emit        = 1'b1;
         emit_status = ST_NEXT_SERVER;
         emit_addr   = item.next_server;
      end else begin
         case (cur)
            PH_CODE: begin
               if (item.option_byte == CODE_END) begin
                  emit = 1'b1;
               end else if (item.option_byte != CODE_PAD) begin
                  phase_in = (item.option_byte == CODE_SERVER_ID) ? PH_LEN_SID : PH_LEN_OTHER;
               end
            end
            PH_LEN_OTHER, PH_LEN_SID: begin
               capt_in  = (cur == PH_LEN_SID) && (item.option_byte == SID_LEN);
               left_in  = item.option_byte;
               addr_in  = '0;
               phase_in = (item.option_byte == 8'd0) ? PH_CODE : PH_VALUE;
            end
            PH_VALUE: begin
               if (capt_ff) begin
                  addr_in = addr_shift;
               end
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  if (capt_ff) begin
                     emit        = 1'b1;
                     emit_status = ST_SERVER_ID;
                     emit_addr   = addr_shift;
                  end else begin
                     phase_in = PH_CODE;
                  end
               end
            end
            default: begin
               // Done: bytes are ignored until the next first byte.
            end
         endcase
         // The area ended without an answer.
         if (!emit && item.last_byte && (cur != PH_DONE)) begin
            emit        = 1'b1;
            emit_status = ST_NOT_FOUND;
            emit_addr   = '0;
         end
      end

      if (emit) begin
         phase_in = PH_DONE;
         left_in  = '0;
         capt_in  = 1'b0;
         addr_in  = '0;
      end

      result.valid       = emit;
      result.status      = emit_status;
      result.server_addr = emit_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         left_ff  <= '0;
         capt_ff  <= 1'b0;
         addr_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         capt_ff  <= capt_in;
         addr_ff  <= addr_in;
      end
   end

endmodule

// ===== hw/rtl/dhcpv4_server_address_select_unit.sv =====
// Top level of the DHCPv4 server address select unit.
// The unit takes one options-area byte per request and can accept a request in every
// cycle while req_stall is low. Each request goes into an input register, then
// through the combinational option walk logic, and any result lands in an output
// register. A result held by rsp_stall keeps the walk from advancing; the input
// register then fills and req_stall rises.
module dhcpv4_server_address_select_unit
   import dsas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_option_byte,
   input  logic        req_first_byte,
   input  logic [31:0] req_next_server,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output status_type  rsp_status,
   output logic [31:0] rsp_server_addr
);

   logic        in_valid_ff, in_valid_in;
   item_type    in_item_ff;
   logic        out_free, advance, req_take;
   result_type  result;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff;
   logic [31:0] rsp_addr_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = out_free ? (advance && result.valid) : rsp_valid_ff;

   dsas_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.option_byte <= req_option_byte;
         in_item_ff.first_byte  <= req_first_byte;
         in_item_ff.next_server <= req_next_server;
         in_item_ff.last_byte   <= req_last_byte;
      end
      if (advance && result.valid) begin
         rsp_status_ff <= result.status;
         rsp_addr_ff   <= result.server_addr;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_server_addr = rsp_addr_ff;

endmodule

// ===== hw/rtl/dsas_checker.sv =====
// Port-level checks of the DHCPv4 server address select unit and their binding.
`include "assert_macros.svh"

module dsas_checker
   import dsas_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input status_type  rsp_status,
   input logic [31:0] rsp_server_addr
);

   logic status_known;
   logic not_found_rsp;
   logic next_server_rsp;

   assign status_known    = (rsp_status == ST_NEXT_SERVER) || (rsp_status == ST_SERVER_ID) ||
                            (rsp_status == ST_NOT_FOUND);
   assign not_found_rsp   = rsp_valid && (rsp_status == ST_NOT_FOUND);
   assign next_server_rsp = rsp_valid && (rsp_status == ST_NEXT_SERVER);

   // A stalled result stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Only the three defined status codes are ever reported.
   `ASSERT_SAME(a_status_code, clock, reset, rsp_valid, status_known)

   // A walk that found nothing reports a cleared address.
   `ASSERT_SAME(a_not_found_zero, clock, reset, not_found_rsp, rsp_server_addr == 32'd0)

   // The next-server address is only used when it is nonzero.
   `ASSERT_SAME(a_next_server_set, clock, reset, next_server_rsp, rsp_server_addr != 32'd0)

endmodule

bind dhcpv4_server_address_select_unit dsas_checker u_dsas_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_server_addr (rsp_server_addr)
);
